@@ rtl/cidrc_pkg.sv @@
// Package for the CAN identifier rate counter: request and result types,
// register indexes and default table size. No dependencies.
package cidrc_pkg;

  localparam int unsigned TableSizeDef = 32;
  localparam int unsigned IdW          = 32;
  localparam int unsigned CountW       = 32;
  localparam int unsigned TicksW       = 6;
  localparam int unsigned IndexOutW    = 5;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 32;

  localparam logic [CfgIdxW-1:0] REG_TIME_MODE = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_SYNC_ID   = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]    msg_id;
    logic [TicksW-1:0] sync_ticks;
    logic              new_second;
  } req_t;

  typedef struct packed {
    logic [IndexOutW-1:0] entry_index;
    logic [IdW-1:0]       entry_id;
    logic [CountW-1:0]    entry_count;
    logic [IndexOutW-1:0] entries_in_use;
    logic [CountW-1:0]    total_count;
    logic                 table_empty;
    logic                 is_last;
  } res_t;

endpackage

@@ rtl/cidrc_req_if.sv @@
// Request channel interface: valid, ready and one received message.
// Depends on cidrc_pkg.
interface cidrc_req_if import cidrc_pkg::*; ();
  logic valid;
  logic ready;
  req_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

@@ rtl/cidrc_res_if.sv @@
// Result channel interface: valid, ready and one report entry.
// Depends on cidrc_pkg.
interface cidrc_res_if import cidrc_pkg::*; ();
  logic valid;
  logic ready;
  res_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

@@ rtl/cidrc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cidrc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/can_id_rate_counter.sv @@
// Top level of the CAN identifier rate counter: sequencer, learned id and
// count tables in RAM, shared adder and output register.
// Depends on cidrc_pkg, cidrc_req_if, cidrc_res_if and cidrc_ram.

// Each request is one received CAN message. The block learns up to
// TABLE_SIZE-1 distinct nonzero identifiers and counts messages per id. At a
// period boundary (new_second when time_mode_q is clear, or a sync message with
// zero ticks when it is set) it first reports every learned entry with its
// count and the period total, or one empty marker, and clears the counts; then
// it counts the message. One sequencer walks the tables one entry at a time
// through a single RAM read port and one shared 32-bit adder.
// A request searches the learned entries for its id; when it closes a period
// it first sums and then reports them, or gives the empty marker, and the
// result side can stall the report.
// No request is taken until the previous one is done.
module can_id_rate_counter import cidrc_pkg::*; #(
  parameter int unsigned TABLE_SIZE = TableSizeDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  cidrc_req_if.sink           req_i,
  cidrc_res_if.source         res_o
);

  localparam int unsigned IdxW = $clog2(TABLE_SIZE);
  localparam logic [IdxW-1:0] MaxUsed = IdxW'(TABLE_SIZE - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EMPTY    = 4'd1;
  localparam logic [3:0] S_SUM_RD   = 4'd2;
  localparam logic [3:0] S_SUM_ACC  = 4'd3;
  localparam logic [3:0] S_DUMP_RD  = 4'd4;
  localparam logic [3:0] S_DUMP_OUT = 4'd5;
  localparam logic [3:0] S_FIND     = 4'd6;
  localparam logic [3:0] S_SRCH_RD  = 4'd7;
  localparam logic [3:0] S_SRCH_CMP = 4'd8;
  localparam logic [3:0] S_APPEND   = 4'd9;

  logic [3:0]        st_q, st_d;
  logic              time_mode_q;
  logic [IdW-1:0]    sync_id_q;
  logic [IdxW-1:0]   used_q, used_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdW-1:0]    id_q, id_d;
  logic [CountW-1:0] total_q, total_d;
  res_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              req_acc;
  logic              boundary;
  logic              out_free;
  logic              idx_last;
  logic [CountW-1:0] add_a, add_sum;
  logic [IdW-1:0]    id_rd;
  logic [CountW-1:0] cnt_rd;
  logic              id_we, cnt_we;
  logic [IdxW-1:0]   wr_addr;
  logic [CountW-1:0] cnt_wdata;

  assign req_i.ready = (st_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign boundary    = time_mode_q
                     ? ((req_i.item.msg_id == sync_id_q) && (req_i.item.sync_ticks == '0))
                     : req_i.item.new_second;
  assign out_free    = !out_valid_q || res_o.ready;
  assign idx_last    = (IdxW'(idx_q + 1'b1) == used_q);
  assign add_a       = (st_q == S_SUM_ACC) ? total_q : CountW'(1);
  assign add_sum     = add_a + cnt_rd;

  assign res_o.valid = out_valid_q;
  assign res_o.item  = out_q;

  cidrc_ram #(.Width(IdW), .Depth(TABLE_SIZE)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (id_we),
    .waddr_i (wr_addr),
    .wdata_i (id_q),
    .raddr_i (idx_q),
    .rdata_o (id_rd)
  );

  cidrc_ram #(.Width(CountW), .Depth(TABLE_SIZE)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (wr_addr),
    .wdata_i (cnt_wdata),
    .raddr_i (idx_q),
    .rdata_o (cnt_rd)
  );

  always_comb begin
    st_d        = st_q;
    used_d      = used_q;
    idx_d       = idx_q;
    id_d        = id_q;
    total_d     = total_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_o.ready;
    id_we       = 1'b0;
    cnt_we      = 1'b0;
    wr_addr     = idx_q;
    cnt_wdata   = '0;
    case (st_q)
      S_IDLE: begin
        if (req_acc) begin
          id_d    = req_i.item.msg_id;
          idx_d   = '0;
          total_d = '0;
          if (!boundary) begin
            st_d = S_FIND;
          end else if (used_q == '0) begin
            st_d = S_EMPTY;
          end else begin
            st_d = S_SUM_RD;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_d             = '0;
          out_d.table_empty = 1'b1;
          out_d.is_last     = 1'b1;
          out_valid_d       = 1'b1;
          st_d              = S_FIND;
        end
      end
      S_SUM_RD: begin
        st_d = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        total_d = add_sum;
        if (idx_last) begin
          idx_d = '0;
          st_d  = S_DUMP_RD;
        end else begin
          idx_d = idx_q + 1'b1;
          st_d  = S_SUM_RD;
        end
      end
      S_DUMP_RD: begin
        st_d = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (out_free) begin
          out_d.entry_index    = IndexOutW'(idx_q);
          out_d.entry_id       = id_rd;
          out_d.entry_count    = cnt_rd;
          out_d.entries_in_use = IndexOutW'(used_q);
          out_d.total_count    = total_q;
          out_d.table_empty    = 1'b0;
          out_d.is_last        = idx_last;
          out_valid_d          = 1'b1;
          cnt_we               = 1'b1;
          if (idx_last) begin
            st_d = S_FIND;
          end else begin
            idx_d = idx_q + 1'b1;
            st_d  = S_DUMP_RD;
          end
        end
      end
      S_FIND: begin
        idx_d = '0;
        if (id_q == '0) begin
          st_d = S_IDLE;
        end else if (used_q == '0) begin
          st_d = S_APPEND;
        end else begin
          st_d = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        st_d = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (id_rd == id_q) begin
          cnt_we    = 1'b1;
          cnt_wdata = add_sum;
          st_d      = S_IDLE;
        end else if (idx_last) begin
          st_d = S_APPEND;
        end else begin
          idx_d = idx_q + 1'b1;
          st_d  = S_SRCH_RD;
        end
      end
      S_APPEND: begin
        wr_addr = used_q;
        if (used_q != MaxUsed) begin
          id_we     = 1'b1;
          cnt_we    = 1'b1;
          cnt_wdata = CountW'(1);
          used_d    = used_q + 1'b1;
        end
        st_d = S_IDLE;
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      time_mode_q <= 1'b0;
      sync_id_q   <= '0;
    end else begin
      st_q        <= st_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TIME_MODE: time_mode_q <= cfg_wdata_i[0];
          REG_SYNC_ID:   sync_id_q   <= cfg_wdata_i[IdW-1:0];
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    id_q    <= id_d;
    total_q <= total_d;
    out_q   <= out_d;
  end

`ifndef SYNTHESIS
  a_zero_id_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && (req_i.item.msg_id == '0) && !boundary |=> ##1 st_q == S_IDLE)
    else $error("zero id without boundary did not return to idle");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q != $past(used_q) |-> (used_q == $past(used_q) + 1'b1) && ($past(st_q) == S_APPEND))
    else $error("learned entry count changed outside append");

  a_last_ends_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DUMP_OUT) && out_free && idx_last |=> st_q == S_FIND)
    else $error("report did not end after last entry");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_APPEND) && (used_q == MaxUsed) |=> used_q == MaxUsed)
    else $error("full table learned a new id");
`endif

endmodule
